@@ src/smscd_pkg.sv @@
`default_nettype none

package smscd_pkg;

    // Default matrix size and the register's reset value.
    localparam int ROWS_DEF = 8;
    localparam int COLS_DEF = 8;
    localparam logic [15:0] SETTLE_RESET = 16'd10;

    // Frame layout: bit row*8+col, eight bits per row whatever the matrix size.
    localparam int FRAME_W = 64;
    localparam int LINE_W = 8;
    localparam int IDX_W = 3;

    // Outcome of comparing a completed frame with the previous one.
    typedef struct packed {
        logic             moved;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } change_t;

endpackage

`default_nettype wire

@@ src/smscd_change.sv @@
`default_nettype none

module smscd_change (
    input  wire logic [smscd_pkg::FRAME_W-1:0] frame_new,
    input  wire logic [smscd_pkg::FRAME_W-1:0] frame_old,
    output smscd_pkg::change_t                 change
);
    import smscd_pkg::*;

    logic [FRAME_W-1:0] diff;
    logic [LINE_W-1:0]  row_any;
    logic [IDX_W-1:0]   first_row;
    logic [LINE_W-1:0]  row_bits;
    logic [IDX_W-1:0]   first_col;

    assign diff = frame_new ^ frame_old;

    // Find the lowest row holding a difference, then the lowest column in it.
    always_comb begin
        first_row = '0;
        for (int r = 0; r < LINE_W; r++) begin
            row_any[r] = |diff[r*LINE_W +: LINE_W];
        end
        for (int r = LINE_W - 1; r >= 0; r--) begin
            if (row_any[r]) begin
                first_row = IDX_W'(r);
            end
        end
    end

    assign row_bits = diff[{first_row, 3'b000} +: LINE_W];

    always_comb begin
        first_col = '0;
        for (int c = LINE_W - 1; c >= 0; c--) begin
            if (row_bits[c]) begin
                first_col = IDX_W'(c);
            end
        end
    end

    assign change.moved = |row_any;
    assign change.row   = first_row;
    assign change.col   = first_col;

endmodule

`default_nettype wire

@@ src/sensor_matrix_scan_change_detect.sv @@
// Path: a tick beat accepted on s_ passes the input register, then the result
// register, before it is valid on m_; a low m_ready can hold it in between.
// Throughput: one tick beat per cycle, sustained, as long as m_ready is high.
// Reset (aresetn low, synchronous): frames clear, column index 0, settle count
// zero, settle_ticks back to 10, both pipeline stages empty.
`default_nettype none

module sensor_matrix_scan_change_detect #(
    parameter int ROWS = smscd_pkg::ROWS_DEF,
    parameter int COLS = smscd_pkg::COLS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration: the settle_ticks register.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,

    // One beat per scan tick.
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_row_levels,

    // One result beat per tick beat.
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_column_drive,
    output logic             m_scan_done,
    output logic             m_moved,
    output logic [2:0]       m_moved_row,
    output logic [2:0]       m_moved_col,
    output logic [63:0]      m_occupancy
);
    import smscd_pkg::*;

    // Column index at which a frame is complete.
    localparam logic [IDX_W-1:0] LAST_COL = IDX_W'(COLS - 1);

    // Configuration register. The port is always ready; the user must write
    // it only while the block is idle, which the block itself does not enforce.
    logic [15:0] settle_ticks_reg;

    // Input stage: the row levels of one tick, only the rows that exist.
    logic            in_valid_reg;
    logic [ROWS-1:0] row_reg;

    // Scan state.
    logic [IDX_W-1:0]   col_reg,          col_next;
    logic [15:0]        settle_count_reg, settle_count_next;
    logic [FRAME_W-1:0] frame_reg,        frame_next;
    logic [FRAME_W-1:0] prev_reg,         prev_next;

    // Result stage.
    logic               out_valid_reg;
    logic [LINE_W-1:0]  drive_reg,  drive_next;
    logic               done_reg,   done_next;
    change_t            change_reg, change_next;
    logic [FRAME_W-1:0] occ_reg,    occ_next;

    logic               advance;
    logic               sample;
    logic               last_col;
    logic [FRAME_W-1:0] frame_sampled;
    change_t            change;

    assign cfg_ready = 1'b1;

    // The input beat moves into the result register whenever that register
    // is empty or being emptied this cycle; the input register refills in the
    // same cycle, so the pipeline keeps one beat per clock while m_ready is high.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // The column is sampled once the settle wait has run out. A lowered
    // settle_ticks that is already passed samples on the next tick.
    assign sample   = settle_count_reg >= settle_ticks_reg;
    assign last_col = col_reg == LAST_COL;

    // Replace the driven column's cells with the sampled rows; rows beyond
    // the matrix never get written and stay clear.
    always_comb begin
        frame_sampled = frame_reg;
        for (int r = 0; r < ROWS; r++) begin
            frame_sampled[{IDX_W'(r), col_reg}] = row_reg[r];
        end
    end

    smscd_change u_change (
        .frame_new (frame_sampled),
        .frame_old (prev_reg),
        .change    (change)
    );

    always_comb begin
        settle_count_next = settle_count_reg + 16'd1;
        col_next          = col_reg;
        frame_next        = frame_reg;
        prev_next         = prev_reg;
        done_next         = 1'b0;
        change_next       = '0;
        occ_next          = '0;
        if (sample) begin
            settle_count_next = '0;
            frame_next        = frame_sampled;
            if (last_col) begin
                // Frame complete: report it against the previous frame and
                // start the next scan at column zero.
                col_next    = '0;
                prev_next   = frame_sampled;
                done_next   = 1'b1;
                change_next = change;
                occ_next    = frame_sampled;
            end else begin
                col_next = col_reg + IDX_W'(1);
            end
        end
        drive_next = LINE_W'(1) << col_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_ticks_reg <= SETTLE_RESET;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            col_reg          <= '0;
            settle_count_reg <= '0;
            frame_reg        <= '0;
            prev_reg         <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                settle_ticks_reg <= cfg_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg    <= 1'b1;
                col_reg          <= col_next;
                settle_count_reg <= settle_count_next;
                frame_reg        <= frame_next;
                prev_reg         <= prev_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; their valid bits guard them.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            row_reg <= s_row_levels[ROWS-1:0];
        end
        if (advance) begin
            drive_reg  <= drive_next;
            done_reg   <= done_next;
            change_reg <= change_next;
            occ_reg    <= occ_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_column_drive = drive_reg;
    assign m_scan_done    = done_reg;
    assign m_moved        = change_reg.moved;
    assign m_moved_row    = change_reg.row;
    assign m_moved_col    = change_reg.col;
    assign m_occupancy    = occ_reg;

endmodule

`default_nettype wire

@@ src/smscd_check.sv @@
`default_nettype none

module smscd_check (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_column_drive,
    input wire logic        m_scan_done,
    input wire logic        m_moved,
    input wire logic [2:0]  m_moved_row,
    input wire logic [2:0]  m_moved_col,
    input wire logic [63:0] m_occupancy
);

    // Exactly one column is driven on every result beat.
    a_drive_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot(m_column_drive))
        else $error("column_drive is not one-hot");

    // A completed scan always restarts at column zero.
    a_done_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_scan_done |-> m_column_drive == 8'h01)
        else $error("scan completed without returning to column zero");

    // Without a completed scan there is nothing to report.
    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_scan_done |-> !m_moved && m_moved_row == 3'd0
            && m_moved_col == 3'd0 && m_occupancy == 64'd0)
        else $error("change fields set on a tick without a completed scan");

    // A stalled result beat holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_column_drive)
            && $stable(m_scan_done) && $stable(m_moved) && $stable(m_occupancy))
        else $error("result beat changed while stalled");

endmodule

bind sensor_matrix_scan_change_detect smscd_check u_smscd_check (.*);

`default_nettype wire
